// ===== rtl/core/wpe_pkg.sv =====
// Shared definitions for the waveform peak envelope block.
// Widths, register indexes, state codes, lane control types and the sample magnitude function.
// No dependencies.
package wpe_pkg;

   localparam int MAX_PIXELS = 4096;
   localparam int FRAC_BITS  = 8;

   localparam int SAMPLE_W   = 32;
   localparam int MAG_W      = 32;
   localparam int HH_W       = 11;
   localparam int SPP_W      = 24;
   localparam int FMT_W      = 2;
   localparam int LIMIT_W    = 13;
   localparam int PIX_W      = 13;
   localparam int IDX_W      = $clog2(MAX_PIXELS);
   localparam int Y_W        = 12;
   localparam int CNT_W      = 32;
   localparam int POS_W      = CNT_W + FRAC_BITS + 1;
   localparam int PROD_W     = MAG_W + HH_W;
   localparam int DIV_CNT_W  = $clog2(PROD_W + 1);
   localparam int RES_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // step = floor(spp / (10 << FRAC_BITS)) = floor((spp >> (FRAC_BITS+1)) / 5)
   localparam int STEP_SHIFT   = FRAC_BITS + 1;
   localparam int STEP_IN_W    = SPP_W - STEP_SHIFT;
   localparam int RECIP_W      = 16;
   localparam int RECIP_SHIFT  = 18;
   localparam int STEP_PROD_W  = STEP_IN_W + RECIP_W;
   localparam int STEP_Q_W     = STEP_PROD_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] STEP_RECIP = RECIP_W'(52429);

   localparam logic [SPP_W-1:0]   SPP_ONE   = SPP_W'(1 << FRAC_BITS);
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(MAX_PIXELS);
   localparam logic [7:0]         OFFSET8   = 8'd127;

   localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
   localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
   localparam logic [FMT_W-1:0] FMT_S32 = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SPP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT  = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_CLOSE,
      ST_TAKE,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic close;
      logic seed;
      logic scale;
      logic take;
      logic shift;
   } lane_ctl_type;

   typedef struct packed {
      logic            busy;
      logic [HH_W-1:0] q;
   } lane_stat_type;

   function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_W-1:0] raw,
                                                  input logic [FMT_W-1:0] fmt);
      logic [7:0]       b;
      logic [15:0]      h;
      logic [MAG_W-1:0] mag;
      b = raw[7:0];
      h = raw[15:0];
      case (fmt)
         FMT_U8: begin
            mag = (b >= OFFSET8) ? MAG_W'(b - OFFSET8) : MAG_W'(OFFSET8 - b);
         end
         FMT_S16: begin
            mag = h[15] ? MAG_W'(17'h10000 - {1'b0, h}) : MAG_W'(h);
         end
         default: begin
            mag = raw[SAMPLE_W-1] ? (MAG_W'(0) - raw) : raw;
         end
      endcase
      return mag;
   endfunction

endpackage

// ===== rtl/core/wpe_divider.sv =====
// Scaling unit: q = min(half, floor(mag * half / peak)), restoring division, one bit a cycle.
// Depends on wpe_pkg.
module wpe_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [wpe_pkg::MAG_W-1:0]  mag,
   input  logic [wpe_pkg::HH_W-1:0]   half,
   input  logic [wpe_pkg::MAG_W-1:0]  peak,
   output logic                       busy,
   output logic [wpe_pkg::HH_W-1:0]   q
);
   import wpe_pkg::*;

   logic [PROD_W-1:0]    num_ff, num_in;
   logic [PROD_W-1:0]    quot_ff, quot_in;
   logic [MAG_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 mag_nz_ff, mag_nz_in;
   logic [HH_W-1:0]      q_ff, q_in;

   logic [MAG_W:0]     rem_sh;
   logic [MAG_W:0]     rem_sub;
   logic               ge;
   logic [MAG_W-1:0]   rem_next;
   logic [PROD_W-1:0]  quot_next;
   logic [HH_W-1:0]    q_final;

   always_comb begin
      rem_sh    = {rem_ff, num_ff[PROD_W-1]};
      rem_sub   = rem_sh - {1'b0, peak};
      ge        = rem_sh >= {1'b0, peak};
      rem_next  = ge ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];
      quot_next = {quot_ff[PROD_W-2:0], ge};
      if (peak == '0) begin
         q_final = mag_nz_ff ? half : '0;
      end else if (quot_next > PROD_W'(half)) begin
         q_final = half;
      end else begin
         q_final = quot_next[HH_W-1:0];
      end
   end

   always_comb begin
      num_in    = num_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      mag_nz_in = mag_nz_ff;
      q_in      = q_ff;
      if (start) begin
         num_in    = PROD_W'(mag) * PROD_W'(half);
         quot_in   = '0;
         rem_in    = '0;
         cnt_in    = DIV_CNT_W'(PROD_W);
         busy_in   = 1'b1;
         mag_nz_in = |mag;
      end else if (busy_ff) begin
         num_in  = {num_ff[PROD_W-2:0], 1'b0};
         quot_in = quot_next;
         rem_in  = rem_next;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            q_in    = q_final;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff    <= num_in;
      quot_ff   <= quot_in;
      rem_ff    <= rem_in;
      mag_nz_ff <= mag_nz_in;
      q_ff      <= q_in;
   end

   assign busy = busy_ff;
   assign q    = q_ff;

endmodule

// ===== rtl/core/wpe_lane.sv =====
// One channel lane: sample magnitude, window maximum, previous-frame magnitude and scaling unit.
// Depends on wpe_pkg and wpe_divider.
module wpe_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [wpe_pkg::SAMPLE_W-1:0]   sample,
   input  logic                           enable,
   input  logic [wpe_pkg::FMT_W-1:0]      fmt,
   input  logic [wpe_pkg::HH_W-1:0]       half,
   input  logic [wpe_pkg::MAG_W-1:0]      peak,
   input  wpe_pkg::lane_ctl_type          ctl,
   output wpe_pkg::lane_stat_type         stat
);
   import wpe_pkg::*;

   logic [MAG_W-1:0] mag_ff, mag_in;
   logic [MAG_W-1:0] prev_ff, prev_in;
   logic [MAG_W-1:0] wmax_ff, wmax_in;
   logic             div_busy;
   logic [HH_W-1:0]  div_q;

   always_comb begin
      mag_in  = mag_ff;
      prev_in = prev_ff;
      wmax_in = wmax_ff;
      if (ctl.load) begin
         mag_in = enable ? magnitude(sample, fmt) : '0;
      end
      if (ctl.clear) begin
         wmax_in = '0;
      end else if (ctl.close) begin
         wmax_in = ctl.seed ? prev_ff : '0;
      end else if (ctl.take && (mag_ff > wmax_ff)) begin
         wmax_in = mag_ff;
      end
      if (ctl.shift) begin
         prev_in = mag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff  <= '0;
         prev_ff <= '0;
         wmax_ff <= '0;
      end else begin
         mag_ff  <= mag_in;
         prev_ff <= prev_in;
         wmax_ff <= wmax_in;
      end
   end

   wpe_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (ctl.scale),
      .mag   (wmax_ff),
      .half  (half),
      .peak  (peak),
      .busy  (div_busy),
      .q     (div_q)
   );

   assign stat.busy = div_busy;
   assign stat.q    = div_q;

endmodule

// ===== rtl/core/waveform_peak_envelope.sv =====
// Top level: configuration registers, window sequencer, two channel lanes and result merge.
// Depends on wpe_pkg and wpe_lane.
//
//  port group | dir | contents
//  req_*      | in  | tdata {right_sample, left_sample}, tuser first_sample, tlast last_sample
//  rsp_*      | out | tdata {y_offset, pixel_index}, tuser channel, tlast last_of_run
//  csr_*      | in  | register index and write data, always ready
//
// A request passes through accept, count, close check and take when no pixel closes;
// the first frame skips the close check, a request with no range active ends after count,
// results follow take; a closing pixel first waits on the bit-serial scaling unit of each lane.
// One request is in flight at a time; a stalled result holds req_tready low.
// Synchronous reset returns the configuration to defaults and the range to idle.
module waveform_peak_envelope (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // left_sample[31:0], right_sample[63:32]
   input  logic [0:0]  req_tuser,   // first_sample[0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // pixel_index[11:0], y_offset[23:12]
   output logic [0:0]  rsp_tuser,   // channel[0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [wpe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wpe_pkg::CSR_DATA_W-1:0] csr_data
);
   import wpe_pkg::*;

   state_type state_ff, state_in;

   logic [SPP_W-1:0]    spp_ff, spp_in;
   logic [FMT_W-1:0]    fmt_ff, fmt_in;
   logic                stereo_ff, stereo_in;
   logic [HH_W-1:0]     half_ff, half_in;
   logic [MAG_W-1:0]    peak_ff, peak_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [STEP_Q_W-1:0] step_ff, step_in;

   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PIX_W-1:0]    pix_ff, pix_in;
   logic [POS_W-1:0]    wend_ff, wend_in;
   logic [POS_W-1:0]    ntake_ff, ntake_in;
   logic                active_ff, active_in;
   logic                first_ff, first_in;
   logic                last_ff, last_in;
   logic                emit_ff, emit_in;
   logic                window_ff, window_in;
   logic [IDX_W-1:0]    pix_out_ff, pix_out_in;
   logic [RES_W-1:0]    idx_ff, idx_in;
   logic [RES_W-1:0]    last_idx_ff, last_idx_in;

   logic                   accept;
   logic [SPP_W-1:0]       spp_eff;
   logic [STEP_PROD_W-1:0] step_prod;
   logic [STEP_Q_W-1:0]    step_q;
   logic [LIMIT_W-1:0]     lim;
   logic [POS_W-1:0]       pos;
   logic [POS_W-1:0]       step_pos;
   logic                   closing;
   logic                   seed;
   logic                   room;
   logic                   take_ok;

   lane_ctl_type  ctl;
   lane_stat_type stat_l, stat_r;

   logic [HH_W-1:0] q_sel;
   logic [Y_W-1:0]  y_mag;
   logic [Y_W-1:0]  y_out;
   logic            chan_out;

   assign accept = req_tvalid & req_tready;

   always_comb begin
      spp_eff   = (spp_ff < SPP_ONE) ? SPP_ONE : spp_ff;
      step_prod = STEP_PROD_W'(spp_eff[SPP_W-1:STEP_SHIFT]) * STEP_PROD_W'(STEP_RECIP);
      step_q    = step_prod[STEP_PROD_W-1:RECIP_SHIFT];
      step_in   = (step_q == '0) ? STEP_Q_W'(1) : step_q;
      lim       = (limit_ff > LIMIT_MAX) ? LIMIT_MAX : limit_ff;
      pos       = POS_W'({cnt_ff, {FRAC_BITS{1'b0}}});
      step_pos  = POS_W'({step_ff, {FRAC_BITS{1'b0}}});
      closing   = pos >= wend_ff;
      seed      = (wend_ff >> FRAC_BITS) < POS_W'(cnt_ff);
      room      = pix_ff < lim;
      take_ok   = (ntake_ff < wend_ff) && ((ntake_ff >> FRAC_BITS) <= POS_W'(cnt_ff));
   end

   // configuration writes
   always_comb begin
      spp_in    = spp_ff;
      fmt_in    = fmt_ff;
      stereo_in = stereo_ff;
      half_in   = half_ff;
      peak_in   = peak_ff;
      limit_in  = limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SPP:    spp_in    = csr_data[SPP_W-1:0];
            CSR_FORMAT: fmt_in    = csr_data[FMT_W-1:0];
            CSR_STEREO: stereo_in = csr_data[0];
            CSR_HALF:   half_in   = csr_data[HH_W-1:0];
            CSR_PEAK:   peak_in   = csr_data[MAG_W-1:0];
            CSR_LIMIT:  limit_in  = csr_data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_COUNT;
         end
         ST_COUNT: begin
            if (first_ff) begin
               state_in = ST_TAKE;
            end else if (active_ff) begin
               state_in = ST_CLOSE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CLOSE: begin
            state_in = ST_TAKE;
         end
         ST_TAKE: begin
            if (!emit_ff) begin
               state_in = ST_IDLE;
            end else if (window_ff) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_DIV: begin
            if (!stat_l.busy) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready && (idx_ff == last_idx_ff)) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // handshakes and lane control
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_EMIT);
      csr_ready  = 1'b1;
      ctl.load   = accept;
      ctl.clear  = (state_ff == ST_COUNT) && first_ff;
      ctl.close  = (state_ff == ST_CLOSE) && closing;
      ctl.seed   = seed;
      ctl.scale  = (state_ff == ST_CLOSE) && closing && room;
      ctl.take   = (state_ff == ST_TAKE) && take_ok;
      ctl.shift  = (state_ff == ST_TAKE);
   end

   // window sequencer
   always_comb begin
      cnt_in      = cnt_ff;
      pix_in      = pix_ff;
      wend_in     = wend_ff;
      ntake_in    = ntake_ff;
      active_in   = active_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      emit_in     = emit_ff;
      window_in   = window_ff;
      pix_out_in  = pix_out_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               first_in  = req_tuser[0];
               last_in   = req_tlast;
               emit_in   = 1'b0;
               window_in = 1'b0;
            end
         end
         ST_COUNT: begin
            if (first_ff) begin
               cnt_in      = '0;
               pix_in      = '0;
               wend_in     = POS_W'(spp_eff);
               ntake_in    = '0;
               active_in   = 1'b1;
               emit_in     = 1'b1;
               pix_out_in  = '0;
               idx_in      = '0;
               last_idx_in = stereo_ff ? RES_W'(1) : RES_W'(0);
            end else if (active_ff && (cnt_ff != '1)) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_CLOSE: begin
            if (closing) begin
               if (room) begin
                  emit_in     = 1'b1;
                  window_in   = 1'b1;
                  pix_out_in  = pix_ff[IDX_W-1:0];
                  pix_in      = pix_ff + 1'b1;
                  idx_in      = '0;
                  last_idx_in = stereo_ff ? RES_W'(3) : RES_W'(1);
               end
               wend_in  = wend_ff + POS_W'(spp_eff);
               ntake_in = seed ? (wend_ff + step_pos) : wend_ff;
            end
         end
         ST_TAKE: begin
            if (take_ok) ntake_in = ntake_ff + step_pos;
            if (last_ff) active_in = 1'b0;
         end
         ST_EMIT: begin
            if (rsp_tready) idx_in = idx_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         spp_ff    <= SPP_ONE;
         fmt_ff    <= FMT_U8;
         stereo_ff <= 1'b0;
         half_ff   <= '0;
         peak_ff   <= MAG_W'(1);
         limit_ff  <= LIMIT_MAX;
         step_ff   <= STEP_Q_W'(1);
         cnt_ff    <= '0;
         pix_ff    <= '0;
         wend_ff   <= '0;
         ntake_ff  <= '0;
         active_ff <= 1'b0;
         emit_ff   <= 1'b0;
         window_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         spp_ff    <= spp_in;
         fmt_ff    <= fmt_in;
         stereo_ff <= stereo_in;
         half_ff   <= half_in;
         peak_ff   <= peak_in;
         limit_ff  <= limit_in;
         step_ff   <= step_in;
         cnt_ff    <= cnt_in;
         pix_ff    <= pix_in;
         wend_ff   <= wend_in;
         ntake_ff  <= ntake_in;
         active_ff <= active_in;
         emit_ff   <= emit_in;
         window_ff <= window_in;
         idx_ff    <= idx_in;
      end
      first_ff    <= first_in;
      last_ff     <= last_in;
      pix_out_ff  <= pix_out_in;
      last_idx_ff <= last_idx_in;
   end

   wpe_lane u_lane_l (
      .clock  (clock),
      .reset  (reset),
      .sample (req_tdata[31:0]),
      .enable (1'b1),
      .fmt    (fmt_ff),
      .half   (half_ff),
      .peak   (peak_ff),
      .ctl    (ctl),
      .stat   (stat_l)
   );

   wpe_lane u_lane_r (
      .clock  (clock),
      .reset  (reset),
      .sample (req_tdata[63:32]),
      .enable (stereo_ff),
      .fmt    (fmt_ff),
      .half   (half_ff),
      .peak   (peak_ff),
      .ctl    (ctl),
      .stat   (stat_r)
   );

   // merge: +q then -q per channel, or zero offsets for the first frame
   always_comb begin
      q_sel    = idx_ff[1] ? stat_r.q : stat_l.q;
      y_mag    = window_ff ? Y_W'(q_sel) : '0;
      y_out    = idx_ff[0] ? (Y_W'(0) - y_mag) : y_mag;
      chan_out = window_ff ? idx_ff[1] : idx_ff[0];
   end

   assign rsp_tdata    = {y_out, pix_out_ff};
   assign rsp_tuser[0] = chan_out;
   assign rsp_tlast    = (idx_ff == last_idx_ff);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while results pending");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (!stat_l.busy && !stat_r.busy))
      else $error("result shown while scaling unit busy");
   a_pix_bound: assert property (@(posedge clock) disable iff (reset)
      pix_ff <= PIX_W'(LIMIT_MAX))
      else $error("pixel counter past maximum");
   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_COUNT))
      else $error("accepted request not counted");
   a_right_stereo: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> stereo_ff)
      else $error("right channel result in mono mode");

endmodule

// ===== tb/waveform_peak_envelope_tb.sv =====
// Testbench for waveform_peak_envelope: a directed request table, then random sample ranges,
// with each result scored against an in-bench envelope predictor, or the table for typed rows.
// Depends on wpe_pkg and the waveform_peak_envelope RTL.
`timescale 1ns / 100ps

module waveform_peak_envelope_tb;
   import wpe_pkg::*;

   localparam int RAND_ITEMS     = 430;
   localparam int SETTLE_CYCLES  = 64;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int N_DIR          = 41;
   localparam int MAX_REPORTS    = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;
   localparam logic [FMT_W-1:0]     FMT_UNUSED    = 2'd3;

   typedef enum logic {ROW_CSR, ROW_FRAME} row_kind_type;

   // csr rows carry the write data in left
   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [31:0]          left;
      logic [31:0]          right;
      logic                 first;
      logic                 last;
      logic                 typed;
      logic [2:0]           n_zero;
      logic [2:0]           n_close;
      logic [11:0]          pix;
      logic [11:0]          yl;
      logic [11:0]          yr;
   } stim_row_type;

   typedef struct packed {
      logic [11:0] pix;
      logic        ch;
      logic [11:0] y;
      logic        last;
   } column_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   waveform_peak_envelope dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor copy of the registers
   logic [SPP_W-1:0]   cfg_spp    = 24'd256;
   logic [FMT_W-1:0]   cfg_format = FMT_U8;
   logic               cfg_stereo = 1'b0;
   logic [HH_W-1:0]    cfg_half   = '0;
   logic [31:0]        cfg_peak   = 32'd1;
   logic [LIMIT_W-1:0] cfg_limit  = 13'd4096;

   // predictor window state
   logic [31:0] max_l = '0;
   logic [31:0] max_r = '0;
   logic [63:0] win_end = '0;
   logic [63:0] next_take = '0;
   logic [31:0] frame_count = '0;
   logic [31:0] pixel_count = '0;
   logic        in_range = 1'b0;
   logic [31:0] prev_l = '0;
   logic [31:0] prev_r = '0;

   column_result_type step_out[$];
   column_result_type expected_columns[$];

   int  fail_count = 0;
   int  hold_asks = 0;
   bit  steady = 1'b0;
   int  idle_cycles = 0;

   stim_row_type dir_tab [0:N_DIR-1];

   function automatic logic [31:0] sample_mag(input logic [31:0] raw);
      logic [7:0]  b;
      logic [15:0] h;
      b = raw[7:0];
      h = raw[15:0];
      if (cfg_format == FMT_U8)
         return (b >= OFFSET8) ? 32'(b - OFFSET8) : 32'(OFFSET8 - b);
      if (cfg_format == FMT_S16)
         return h[15] ? 32'(17'h10000 - {1'b0, h}) : 32'(h);
      return raw[31] ? 32'd0 - raw : raw;
   endfunction

   function automatic logic [63:0] win_len();
      logic [63:0] s;
      s = 64'(cfg_spp);
      return (s < 64'(SPP_ONE)) ? 64'(SPP_ONE) : s;
   endfunction

   function automatic logic [63:0] take_step();
      logic [63:0] st;
      st = win_len() / (64'd10 << FRAC_BITS);
      if (st == 0)
         st = 1;
      return st << FRAC_BITS;
   endfunction

   function automatic logic [11:0] to_offset(input logic [31:0] m);
      logic [63:0] q;
      if (cfg_peak == 0)
         return (m != 0) ? 12'(cfg_half) : 12'd0;
      q = (64'(m) * 64'(cfg_half)) / 64'(cfg_peak);
      return (q > 64'(cfg_half)) ? 12'(cfg_half) : q[11:0];
   endfunction

   // fills step_out with the results one request causes
   function automatic void envelope_step(input logic [31:0] l_raw, input logic [31:0] r_raw,
                                         input logic first, input logic last);
      logic [31:0] ml;
      logic [31:0] mr;
      logic [31:0] lim;
      logic [63:0] pos;
      logic [63:0] start;
      logic [11:0] q;
      step_out = {};
      ml = sample_mag(l_raw);
      mr = cfg_stereo ? sample_mag(r_raw) : 32'd0;
      lim = (cfg_limit > LIMIT_MAX) ? 32'(LIMIT_MAX) : 32'(cfg_limit);
      if (first) begin
         frame_count = '0;
         pixel_count = '0;
         win_end = win_len();
         next_take = '0;
         max_l = '0;
         max_r = '0;
         in_range = 1'b1;
         step_out.push_back('{12'd0, 1'b0, 12'd0, 1'b0});
         if (cfg_stereo)
            step_out.push_back('{12'd0, 1'b1, 12'd0, 1'b0});
      end else begin
         if (!in_range)
            return;
         if (frame_count != '1)
            frame_count++;
      end
      pos = 64'(frame_count) << FRAC_BITS;
      if (pos >= win_end) begin
         start = win_end;
         if (pixel_count < lim) begin
            q = to_offset(max_l);
            step_out.push_back('{pixel_count[11:0], 1'b0, q, 1'b0});
            step_out.push_back('{pixel_count[11:0], 1'b0, 12'd0 - q, 1'b0});
            if (cfg_stereo) begin
               q = to_offset(max_r);
               step_out.push_back('{pixel_count[11:0], 1'b1, q, 1'b0});
               step_out.push_back('{pixel_count[11:0], 1'b1, 12'd0 - q, 1'b0});
            end
            pixel_count++;
         end
         win_end = start + win_len();
         max_l = '0;
         max_r = '0;
         next_take = start;
         if ((start >> FRAC_BITS) < 64'(frame_count)) begin
            max_l = prev_l;
            max_r = prev_r;
            next_take = start + take_step();
         end
      end
      if (next_take < win_end && (next_take >> FRAC_BITS) <= 64'(frame_count)) begin
         if (ml > max_l)
            max_l = ml;
         if (mr > max_r)
            max_r = mr;
         next_take += take_step();
      end
      prev_l = ml;
      prev_r = mr;
      if (last)
         in_range = 1'b0;
      if (step_out.size() > 0)
         step_out[step_out.size()-1].last = 1'b1;
   endfunction

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom() & 32'h0000_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic stim_row_type rand_frame(input logic first, input logic last);
      stim_row_type row;
      row = '0;
      row.kind = ROW_FRAME;
      row.left = rand_sample();
      row.right = rand_sample();
      row.first = first;
      row.last = last;
      return row;
   endfunction

   task automatic push_frame(input stim_row_type row);
      int k;
      if (!steady && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tdata <= {row.right, row.left};
      req_tuser <= row.first;
      req_tlast <= row.last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      envelope_step(row.left, row.right, row.first, row.last);
      if (row.typed) begin
         step_out = {};
         for (k = 0; k < row.n_zero; k++)
            step_out.push_back('{12'd0, 1'(k), 12'd0, 1'b0});
         if (row.n_close != 0) begin
            step_out.push_back('{row.pix, 1'b0, row.yl, 1'b0});
            step_out.push_back('{row.pix, 1'b0, 12'd0 - row.yl, 1'b0});
         end
         if (row.n_close == 4) begin
            step_out.push_back('{row.pix, 1'b1, row.yr, 1'b0});
            step_out.push_back('{row.pix, 1'b1, 12'd0 - row.yr, 1'b0});
         end
         if (step_out.size() > 0)
            step_out[step_out.size()-1].last = 1'b1;
      end
      foreach (step_out[j])
         expected_columns.push_back(step_out[j]);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SPP:    cfg_spp = value[SPP_W-1:0];
         CSR_FORMAT: cfg_format = value[FMT_W-1:0];
         CSR_STEREO: cfg_stereo = value[0];
         CSR_HALF:   cfg_half = value[HH_W-1:0];
         CSR_PEAK:   cfg_peak = value;
         CSR_LIMIT:  cfg_limit = value[LIMIT_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // block idle: nothing outstanding, plus time for a no-result request to finish
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_columns.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin : rsp_side
      int stall_left;
      int served;
      column_result_type got;
      column_result_type want;
      stall_left = 0;
      served = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[11:0], rsp_tuser[0], rsp_tdata[23:12], rsp_tlast};
            if (expected_columns.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected result: pix %0d ch %0d y %0d last %0d",
                           got.pix, got.ch, $signed(got.y), got.last);
            end else begin
               want = expected_columns.pop_front();
               if (got != want) begin
                  fail_count++;
                  // pix ch y last
                  if (fail_count <= MAX_REPORTS)
                     $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                              want.pix, want.ch, $signed(want.y), want.last,
                              got.pix, got.ch, $signed(got.y), got.last);
               end
            end
         end
         if (served < hold_asks) begin
            served++;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 11);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int live;
      int phase;
      int budget;
      int len;
      int max_len;
      int k;
      logic [FMT_W-1:0] fmt;
      logic [31:0] pk;
      stim_row_type row;

      dir_tab = '{
         // frame outside a range, then 8-bit mono up to a saturated column
         '{ROW_FRAME, '0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_CSR, CSR_HALF, 32'd2047, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_CSR, CSR_PEAK, 32'd128, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_FRAME, '0, 32'hFF, 32'h0, 1'b1, 1'b0, 1'b1, 3'd1, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_FRAME, '0, 32'h00, 32'h0, 1'b0, 1'b0, 1'b1, 3'd0, 3'd2, 12'd0, 12'd2047, 12'd0},
         '{ROW_FRAME, '0, 32'h7F, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_FRAME, '0, 32'h80, 32'h0, 1'b0, 1'b1, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         // 16-bit stereo
         '{ROW_CSR, CSR_FORMAT, 32'(FMT_S16), 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_CSR, CSR_STEREO, 32'd1, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_CSR, CSR_PEAK, 32'd32768, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_FRAME, '0, 32'h8000, 32'h7FFF, 1'b1, 1'b0, 1'b1, 3'd2, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_FRAME, '0, 32'hFFFF_0001, 32'h1234_8001, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0,
           12'd0},
         // zero peak, changed mid-range
         '{ROW_CSR, CSR_FORMAT, 32'(FMT_S32), 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_CSR, CSR_PEAK, 32'd0, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_FRAME, '0, 32'h8000_0000, 32'h0, 1'b0, 1'b0, 1'b1, 3'd0, 3'd4, 12'd1, 12'd2047,
           12'd2047},
         '{ROW_FRAME, '0, 32'h5, 32'h8000_0000, 1'b0, 1'b1, 1'b1, 3'd0, 3'd4, 12'd2, 12'd2047,
           12'd0},
         // unused format, full peak, no columns, short window
         '{ROW_CSR, CSR_FORMAT, 32'(FMT_UNUSED), 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0,
           12'd0},
         '{ROW_CSR, CSR_PEAK, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_CSR, CSR_LIMIT, 32'd0, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_CSR, CSR_SPP, 32'd0, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_FRAME, '0, 32'h7FFF_FFFF, 32'h8000_0001, 1'b1, 1'b0, 1'b1, 3'd2, 3'd0, 12'd0, 12'd0,
           12'd0},
         '{ROW_FRAME, '0, 32'h1234_5678, 32'hFEDC_BA98, 1'b0, 1'b0, 1'b1, 3'd0, 3'd0, 12'd0, 12'd0,
           12'd0},
         '{ROW_FRAME, '0, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1, 1'b1, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         // writes to indexes past the register list
         '{ROW_CSR, CSR_UNUSED_LO, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0,
           12'd0},
         '{ROW_CSR, CSR_UNUSED_HI, 32'h5A5A_5A5A, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0,
           12'd0},
         // fractional window, limit above the column count
         '{ROW_CSR, CSR_LIMIT, 32'd8191, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_CSR, CSR_SPP, 32'd640, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_CSR, CSR_STEREO, 32'd0, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_CSR, CSR_FORMAT, 32'(FMT_U8), 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_CSR, CSR_PEAK, 32'd100, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_CSR, CSR_HALF, 32'd1000, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_FRAME, '0, 32'h00, 32'h0, 1'b1, 1'b1, 1'b1, 3'd1, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_FRAME, '0, 32'h10, 32'h0, 1'b1, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_FRAME, '0, 32'hF0, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_FRAME, '0, 32'h40, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_FRAME, '0, 32'h7F, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_FRAME, '0, 32'hC3, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_FRAME, '0, 32'h01, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         // restart while a range is open
         '{ROW_FRAME, '0, 32'hAB, 32'h0, 1'b1, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_FRAME, '0, 32'h22, 32'h0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0},
         '{ROW_FRAME, '0, 32'h99, 32'h0, 1'b0, 1'b1, 1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CSR) begin
            wait_drained();
            write_reg(dir_tab[i].idx, dir_tab[i].left);
         end else begin
            push_frame(dir_tab[i]);
         end
      end

      live = 0;
      phase = 0;
      while (live < RAND_ITEMS) begin
         wait_drained();
         case ($urandom_range(9))
            0: write_reg(CSR_SPP, {8'($urandom()), 24'd256});
            1: write_reg(CSR_SPP, {8'($urandom()), 24'($urandom_range(255))});
            2: write_reg(CSR_SPP, 32'd640);
            3: write_reg(CSR_SPP, 32'd5120);
            4: write_reg(CSR_SPP, 32'h00FF_FFFF);
            5: write_reg(CSR_SPP, 32'($urandom_range(2560, 8000)));
            default: write_reg(CSR_SPP, 32'($urandom_range(257, 1500)));
         endcase
         fmt = 2'($urandom_range(3));
         write_reg(CSR_FORMAT, {30'($urandom()), fmt});
         write_reg(CSR_STEREO, {31'($urandom()), 1'($urandom_range(1))});
         case ($urandom_range(4))
            0: write_reg(CSR_HALF, 32'd0);
            1: write_reg(CSR_HALF, 32'd2047);
            default: write_reg(CSR_HALF, 32'($urandom_range(2047)));
         endcase
         case ($urandom_range(5))
            0: pk = 32'd0;
            1: pk = 32'h8000_0000;
            default: begin
               if (fmt == FMT_U8)
                  pk = 32'($urandom_range(1, 128));
               else if (fmt == FMT_S16)
                  pk = 32'($urandom_range(1, 32768));
               else
                  pk = $urandom();
            end
         endcase
         write_reg(CSR_PEAK, pk);
         case ($urandom_range(6))
            0: write_reg(CSR_LIMIT, 32'd0);
            1: write_reg(CSR_LIMIT, 32'($urandom_range(1, 4)));
            2: write_reg(CSR_LIMIT, 32'd4096);
            3: write_reg(CSR_LIMIT, 32'd8191);
            default: write_reg(CSR_LIMIT, 32'($urandom_range(5, 4095)));
         endcase

         steady = (phase == 2);
         if (phase == 1)
            hold_asks++;

         budget = $urandom_range(30, 70);
         while (budget > 0 && live < RAND_ITEMS) begin
            max_len = 3 * ((cfg_spp >> FRAC_BITS) + 1) + 2;
            if (max_len > 40)
               max_len = 40;
            if ($urandom_range(99) < 6) begin
               // stray frame; ignored unless a range is still open
               if (in_range) begin
                  live++;
                  budget--;
               end
               push_frame(rand_frame(1'b0, 1'b0));
            end else begin
               len = $urandom_range(0, max_len);
               push_frame(rand_frame(1'b1, len == 0 && $urandom_range(1) == 1));
               live++;
               budget--;
               for (k = 0; k < len; k++) begin
                  if (k == len / 2 && $urandom_range(9) == 0) begin
                     wait_drained();
                     write_reg(CSR_HALF, 32'($urandom_range(2047)));
                  end
                  row = rand_frame(1'b0, k == len - 1 && $urandom_range(99) < 85);
                  push_frame(row);
                  live++;
                  budget--;
               end
            end
         end
         phase++;
      end
      steady = 1'b0;

      wait_drained();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/wpe_pkg.sv
rtl/core/wpe_divider.sv
rtl/core/wpe_lane.sv
rtl/core/waveform_peak_envelope.sv
tb/waveform_peak_envelope_tb.sv
